// ===== sv/rred_pkg.sv =====
// Shared types and constants for the run-length repeat/escape decoder.
package rred_pkg;

  localparam int LENGTH_WIDTH = 16;
  localparam int OUT_LANES    = 4;
  localparam int MAX_RESULTS  = 64;

  localparam int LANES   = (OUT_LANES < 1) ? 1 : ((OUT_LANES > 4) ? 4 : OUT_LANES);
  localparam int RUN_CAP = (MAX_RESULTS * LANES > 255) ? 255 : MAX_RESULTS * LANES;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int IN_TDATA_W  = ((8 + LENGTH_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 40;

  typedef logic [LENGTH_WIDTH-1:0] len_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_NORMAL,
    PH_COUNT,
    PH_LITERAL
  } phase_t;

  // One emit command: repeat data count times (count >= 1).
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] count;
    logic       frame_end;
  } cmd_t;

endpackage

// ===== sv/rred_front.sv =====
// Front end: tracks frame phase and remaining length, turns bytes into emit commands.
module rred_front
  import rred_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] data_byte,
  input  logic       frame_start,
  input  len_t       out_length,
  output logic       push,
  output cmd_t       cmd
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] prev_r, prev_nxt;
  len_t       rem_r, rem_nxt;

  len_t       len_dec;
  len_t       rem_dec;
  logic [7:0] run_byte;
  len_t       run_len;
  len_t       rem_after_run;

  assign len_dec       = out_length - LENGTH_WIDTH'(1);
  assign rem_dec       = rem_r - LENGTH_WIDTH'(1);
  assign run_byte      = (data_byte > 8'(RUN_CAP)) ? 8'(RUN_CAP) : data_byte;
  assign run_len       = (rem_r < LENGTH_WIDTH'(run_byte)) ? rem_r : LENGTH_WIDTH'(run_byte);
  assign rem_after_run = rem_r - run_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      prev_r  <= '0;
      rem_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    prev_nxt  = prev_r;
    rem_nxt   = rem_r;
    push      = 1'b0;
    cmd       = '0;
    if (acc) begin
      if (frame_start) begin
        rem_nxt = out_length;
        if (out_length != '0) begin
          push          = 1'b1;
          cmd.data      = data_byte;
          cmd.count     = 8'd1;
          cmd.frame_end = (len_dec == '0);
          rem_nxt       = len_dec;
          prev_nxt      = data_byte;
          phase_nxt     = (len_dec == '0) ? PH_IDLE : PH_NORMAL;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end else begin
        case (phase_r)
          PH_NORMAL: begin
            push          = 1'b1;
            cmd.data      = data_byte;
            cmd.count     = 8'd1;
            cmd.frame_end = (rem_dec == '0);
            rem_nxt       = rem_dec;
            if (data_byte == prev_r) begin
              phase_nxt = PH_COUNT;
            end else begin
              prev_nxt = data_byte;
            end
            if (rem_dec == '0) begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_COUNT: begin
            push          = (run_len != '0);
            cmd.data      = prev_r;
            cmd.count     = run_len[7:0];
            cmd.frame_end = (rem_after_run == '0);
            rem_nxt       = rem_after_run;
            phase_nxt     = (rem_after_run == '0) ? PH_IDLE : PH_LITERAL;
          end
          PH_LITERAL: begin
            push          = 1'b1;
            cmd.data      = data_byte;
            cmd.count     = 8'd1;
            cmd.frame_end = (rem_dec == '0);
            rem_nxt       = rem_dec;
            prev_nxt      = data_byte;
            phase_nxt     = (rem_dec == '0) ? PH_IDLE : PH_NORMAL;
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

endmodule

// ===== sv/rred_fifo.sv =====
// Small command queue between front and back ends.
module rred_fifo
  import rred_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wr_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  cmd_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 :
                    wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 :
                    rd_ptr_r + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - FIFO_CNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/rred_back.sv =====
// Back end: splits emit commands into packed lane words behind an output register.
module rred_back
  import rred_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        head,
  input  logic        empty,
  output logic        pop,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [31:0] out_packed,
  output logic [2:0]  out_count,
  output logic        out_last,
  output logic        out_done
);

  logic        busy_r;
  logic [7:0]  left_r;
  logic        valid_r;
  logic [31:0] packed_r;
  logic [2:0]  count_r;
  logic        last_r;
  logic        done_r;

  logic [7:0]  eff;
  logic [2:0]  chunk;
  logic        final_chunk;
  logic        slot_free;
  logic        go;
  logic [31:0] word;

  assign eff         = busy_r ? left_r : head.count;
  assign final_chunk = (eff <= 8'(LANES));
  assign chunk       = final_chunk ? eff[2:0] : 3'(LANES);
  assign slot_free   = !valid_r || out_ready;
  assign go          = !empty && slot_free;
  assign pop         = go && final_chunk;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      word[8*i +: 8] = (3'(i) < chunk) ? head.data : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      if (go) begin
        busy_r  <= !final_chunk;
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      left_r   <= eff - 8'(LANES);
      packed_r <= word;
      count_r  <= chunk;
      last_r   <= final_chunk;
      done_r   <= final_chunk && head.frame_end;
    end
  end

  assign out_valid  = valid_r;
  assign out_packed = packed_r;
  assign out_count  = count_r;
  assign out_last   = last_r;
  assign out_done   = done_r;

endmodule

// ===== sv/rle_repeat_escape_decoder.sv =====
// Top level of the run-length decoder with doubled-byte escape.
// Each result passes through the command queue and then the back-end output register.
// Throughput: one input byte per cycle for literal bytes; a count byte yields
// ceil(run/4) result words, one per cycle while out_tready is high, set by the back-end lane splitter.
// Input stalls only when the two-entry command queue is full.
// Reset (synchronous, rst_n low): no frame active, remaining length and queue cleared.
module rle_repeat_escape_decoder
  import rred_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // data_byte[7:0], out_length[23:8]
  input  logic                   in_tuser,   // frame_start
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // packed_bytes[31:0], byte_count[34:32], zero pad
  output logic                   out_tuser,  // last_of_item
  output logic                   out_tlast   // frame_done
);

  logic        acc;
  logic        push;
  cmd_t        cmd;
  logic        pop;
  cmd_t        head;
  logic        empty;
  logic        full;
  logic [31:0] packed_bytes;
  logic [2:0]  byte_count;

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  rred_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .data_byte   (in_tdata[7:0]),
    .frame_start (in_tuser),
    .out_length  (in_tdata[8 +: LENGTH_WIDTH]),
    .push        (push),
    .cmd         (cmd)
  );

  rred_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (cmd),
    .pop    (pop),
    .head   (head),
    .empty  (empty),
    .full   (full)
  );

  rred_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_packed (packed_bytes),
    .out_count  (byte_count),
    .out_last   (out_tuser),
    .out_done   (out_tlast)
  );

  assign out_tdata = {5'd0, byte_count, packed_bytes};

endmodule
